[rtl/pngu_pkg.sv]
package pngu_pkg;

   localparam int DEFAULT_MAX_LINE_BYTES  = 4096;
   localparam int DEFAULT_MAX_PIXEL_BYTES = 8;

   localparam int BPP_W         = 4;
   localparam int LINE_LENGTH_W = 13;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [BPP_W-1:0]         BPP_RESET         = 4'd4;
   localparam logic [LINE_LENGTH_W-1:0] LINE_LENGTH_RESET = 13'd4096;

   // Row filter codes as they appear in the filter-type byte.
   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   // Register index, taken from the word address of the CSR port.
   typedef enum logic [0:0] {
      REG_BYTES_PER_PIXEL = 1'b0,
      REG_LINE_LENGTH     = 1'b1
   } reg_index_type;

endpackage

[rtl/png_scanline_unfilter.sv]
// An accepted req beat reaches its rsp beat through the input register and the result register.
// Throughput: one byte per cycle if not stalled; the above-row memory is read one column ahead.
// Reset (synchronous): clears control state, the left and upper-left stores and the error flag,
// and loads the registers with their defaults. The above-row memory is not swept: a fill
// count makes columns not yet written in the current image read as zero.
module png_scanline_unfilter
   import pngu_pkg::*;
#(
   parameter int MAX_LINE_BYTES  = DEFAULT_MAX_LINE_BYTES,
   parameter int MAX_PIXEL_BYTES = DEFAULT_MAX_PIXEL_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_image_start,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_pixel_byte,
   output logic                  rsp_is_filter_slot,
   output logic                  rsp_row_end,
   output logic                  rsp_bad_filter,

   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int COL_W  = (MAX_LINE_BYTES > 2) ? $clog2(MAX_LINE_BYTES) : 1;
   localparam int SLOT_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
   localparam int LEN_W  = (COL_W + 1 > LINE_LENGTH_W) ? COL_W + 1 : LINE_LENGTH_W;
   localparam int CMP_W  = COL_W + BPP_W;

   // Configuration registers.
   logic [BPP_W-1:0]         bpp_ff;
   logic [LINE_LENGTH_W-1:0] len_ff;
   logic                     csr_write;
   reg_index_type            csr_index;

   // Handshake.
   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic [7:0] s1_data_ff;
   logic       s1_start_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;
   logic       fire;
   logic       req_take;

   // Row state and stores.
   logic [COL_W-1:0]  column_ff;
   logic [COL_W-1:0]  column_in;
   logic [COL_W-1:0]  fill_ff;
   logic [COL_W-1:0]  fill_in;
   filter_type        filter_ff;
   filter_type        filter_in;
   logic              error_ff;
   logic              error_in;
   logic [SLOT_W-1:0] res_ff  [MAX_PIXEL_BYTES];
   logic [SLOT_W-1:0] res_in  [MAX_PIXEL_BYTES];
   logic [7:0]        left_ff [MAX_PIXEL_BYTES];
   logic [7:0]        left_in [MAX_PIXEL_BYTES];
   logic [7:0]        ulh_ff  [MAX_PIXEL_BYTES];
   logic [7:0]        ulh_in  [MAX_PIXEL_BYTES];
   logic [7:0]        above_mem [MAX_LINE_BYTES];
   logic [7:0]        above_rd_ff;

   // Per-beat datapath.
   logic [COL_W-1:0]  col_eff;
   logic [COL_W-1:0]  fill_cur;
   logic              error_cur;
   filter_type        filter_cur;
   logic [BPP_W-1:0]  bpp_c;
   logic [SLOT_W-1:0] bpp_idx;
   logic [SLOT_W-1:0] slot;
   logic [LEN_W-1:0]  len_ext;
   logic [LEN_W-1:0]  len_c;
   logic [COL_W-1:0]  len_m1;
   logic              last;
   logic [7:0]        a_byte;
   logic [7:0]        b_byte;
   logic [7:0]        c_byte;
   logic [7:0]        pred;
   logic [7:0]        pix;
   logic              mem_we;

   logic [7:0]        pix_in;
   logic              is_filter_in;
   logic [7:0]        pixel_ff;
   logic              is_filter_ff;
   logic              row_end_ff;
   logic              bad_filter_ff;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff <= BPP_RESET;
         len_ff <= LINE_LENGTH_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_BYTES_PER_PIXEL: bpp_ff <= pwdata[BPP_W-1:0];
            REG_LINE_LENGTH:     len_ff <= pwdata[LINE_LENGTH_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_BYTES_PER_PIXEL: prdata = CSR_DATA_W'(bpp_ff);
         REG_LINE_LENGTH:     prdata = CSR_DATA_W'(len_ff);
      endcase
   end

   // ---------------- handshake ----------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff  <= req_data_byte;
         s1_start_ff <= req_image_start;
      end
   end

   // ---------------- beat datapath ----------------
   // An image start acts as if the stores had been cleared before this beat.
   assign col_eff    = s1_start_ff ? '0 : column_ff;
   assign fill_cur   = s1_start_ff ? '0 : fill_ff;
   assign error_cur  = s1_start_ff ? 1'b0 : error_ff;
   assign filter_cur = s1_start_ff ? FILT_NONE : filter_ff;

   always_comb begin
      priority if (bpp_ff == '0) begin
         bpp_c = BPP_W'(1);
      end else if (bpp_ff > BPP_W'(MAX_PIXEL_BYTES)) begin
         bpp_c = BPP_W'(MAX_PIXEL_BYTES);
      end else begin
         bpp_c = bpp_ff;
      end
   end
   assign bpp_idx = SLOT_W'(bpp_c - BPP_W'(1));
   // res_ff[k] holds (column - 1) mod (k + 1), so no divider is needed.
   assign slot    = res_ff[bpp_idx];

   always_comb begin
      len_ext = LEN_W'(len_ff);
      priority if (len_ext < LEN_W'(2)) begin
         len_c = LEN_W'(2);
      end else if (len_ext > LEN_W'(MAX_LINE_BYTES)) begin
         len_c = LEN_W'(MAX_LINE_BYTES);
      end else begin
         len_c = len_ext;
      end
   end
   assign len_m1 = COL_W'(len_c - LEN_W'(1));
   assign last   = col_eff >= len_m1;

   // Columns past the fill count have not been written since the image began.
   assign a_byte = s1_start_ff ? 8'd0 : left_ff[slot];
   assign b_byte = (col_eff <= fill_cur) ? above_rd_ff : 8'd0;
   assign c_byte = (!s1_start_ff && (CMP_W'(col_eff) > CMP_W'(bpp_c))) ? ulh_ff[slot] : 8'd0;

   pngu_predict u_predict (
      .filter      (filter_cur),
      .left_byte   (a_byte),
      .above_byte  (b_byte),
      .corner_byte (c_byte),
      .pred_byte   (pred)
   );

   assign pix = s1_data_ff + pred;

   always_comb begin
      column_in    = column_ff;
      fill_in      = fill_ff;
      filter_in    = filter_ff;
      error_in     = error_ff;
      mem_we       = 1'b0;
      pix_in       = 8'd0;
      is_filter_in = 1'b0;
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
         res_in[k]  = res_ff[k];
         left_in[k] = s1_start_ff ? 8'd0 : left_ff[k];
         ulh_in[k]  = s1_start_ff ? 8'd0 : ulh_ff[k];
      end
      if (fire) begin
         column_in = last ? '0 : col_eff + COL_W'(1);
         fill_in   = fill_cur;
         filter_in = filter_cur;
         error_in  = error_cur;
         for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            if (col_eff == '0 || last) begin
               res_in[k] = '0;
            end else begin
               res_in[k] = (res_ff[k] == SLOT_W'(k)) ? '0 : res_ff[k] + SLOT_W'(1);
            end
         end
         if (col_eff == '0) begin
            is_filter_in = 1'b1;
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
               left_in[k] = 8'd0;
            end
            if (s1_data_ff > 8'(FILT_PAETH)) begin
               error_in = 1'b1;
            end else begin
               filter_in = filter_type'(s1_data_ff[2:0]);
            end
         end else if (!error_cur) begin
            pix_in        = pix;
            mem_we        = 1'b1;
            left_in[slot] = pix;
            ulh_in[slot]  = b_byte;
            if (col_eff > fill_cur) begin
               fill_in = col_eff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         fill_ff   <= '0;
         filter_ff <= FILT_NONE;
         error_ff  <= 1'b0;
         for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            res_ff[k]  <= '0;
            left_ff[k] <= 8'd0;
            ulh_ff[k]  <= 8'd0;
         end
      end else if (fire) begin
         column_ff <= column_in;
         fill_ff   <= fill_in;
         filter_ff <= filter_in;
         error_ff  <= error_in;
         for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            res_ff[k]  <= res_in[k];
            left_ff[k] <= left_in[k];
            ulh_ff[k]  <= ulh_in[k];
         end
      end
   end

   // The read address is the column of the next beat, so its above byte is registered
   // in above_rd_ff before that beat fires; a beat never writes the column it prefetches.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         above_mem[col_eff] <= pix;
      end
   end

   always_ff @(posedge clock) begin
      above_rd_ff <= above_mem[column_in];
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (fire) begin
         pixel_ff      <= pix_in;
         is_filter_ff  <= is_filter_in;
         row_end_ff    <= last;
         bad_filter_ff <= error_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_byte     = pixel_ff;
   assign rsp_is_filter_slot = is_filter_ff;
   assign rsp_row_end        = row_end_ff;
   assign rsp_bad_filter     = bad_filter_ff;

   // ---------------- assertions ----------------
   a_filter_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_filter_slot |-> rsp_pixel_byte == 8'd0)
      else $error("filter slot beat carries a nonzero pixel byte");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_filter |-> rsp_pixel_byte == 8'd0)
      else $error("pixel byte not zero while the filter error is latched");

   a_fill_prefix: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (COL_W + 1)'(col_eff) <= (COL_W + 1)'(fill_cur) + (COL_W + 1)'(1))
      else $error("above-row write skips past the fill count");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("input stalled with room in the pipeline");

endmodule

[rtl/pngu_predict.sv]
module pngu_predict
   import pngu_pkg::*;
(
   input  filter_type  filter,
   input  logic [7:0]  left_byte,
   input  logic [7:0]  above_byte,
   input  logic [7:0]  corner_byte,
   output logic [7:0]  pred_byte
);

   logic signed [9:0] diff_bc;
   logic signed [9:0] diff_ac;
   logic signed [9:0] diff_abc;
   logic [9:0]        dist_a;
   logic [9:0]        dist_b;
   logic [9:0]        dist_c;
   logic [8:0]        sum_ab;
   logic [7:0]        paeth_byte;

   assign diff_bc  = $signed({2'b00, above_byte}) - $signed({2'b00, corner_byte});
   assign diff_ac  = $signed({2'b00, left_byte}) - $signed({2'b00, corner_byte});
   assign diff_abc = diff_ac + diff_bc;

   assign dist_a = diff_bc[9]  ? 10'(-diff_bc)  : 10'(diff_bc);
   assign dist_b = diff_ac[9]  ? 10'(-diff_ac)  : 10'(diff_ac);
   assign dist_c = diff_abc[9] ? 10'(-diff_abc) : 10'(diff_abc);

   assign sum_ab = {1'b0, left_byte} + {1'b0, above_byte};

   // Ties go to left, then above, then upper-left.
   always_comb begin
      priority if (dist_a <= dist_b && dist_a <= dist_c) begin
         paeth_byte = left_byte;
      end else if (dist_b <= dist_c) begin
         paeth_byte = above_byte;
      end else begin
         paeth_byte = corner_byte;
      end
   end

   always_comb begin
      unique case (filter)
         FILT_SUB:   pred_byte = left_byte;
         FILT_UP:    pred_byte = above_byte;
         FILT_AVG:   pred_byte = sum_ab[8:1];
         FILT_PAETH: pred_byte = paeth_byte;
         default:    pred_byte = 8'd0;
      endcase
   end

endmodule

[verif/png_scanline_unfilter_tb.sv]
module png_scanline_unfilter_tb;
   import pngu_pkg::*;

   localparam int LINE_CAP     = DEFAULT_MAX_LINE_BYTES;
   localparam int PIXEL_CAP    = DEFAULT_MAX_PIXEL_BYTES;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_TRIGGER = 400;
   localparam int HOLD_CYCLES  = 250;
   localparam int IDLE_PCT     = 17;

   localparam logic [7:0] FILTER_CODE_BAD = 8'd7;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
   } stream_byte_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic       filter_slot;
      logic       row_end;
      logic       bad;
   } pixel_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_data_byte = 8'h00;
   logic                  req_image_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [7:0]            rsp_pixel_byte;
   logic                  rsp_is_filter_slot;
   logic                  rsp_row_end;
   logic                  rsp_bad_filter;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   png_scanline_unfilter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_image_start    (req_image_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_byte     (rsp_pixel_byte),
      .rsp_is_filter_slot (rsp_is_filter_slot),
      .rsp_row_end        (rsp_row_end),
      .rsp_bad_filter     (rsp_bad_filter),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #10 clock = ~clock;

   // Predictor state: the reconstruction stores and the register copies.
   logic [7:0]               above_bytes [LINE_CAP];
   logic [7:0]               left_bytes [PIXEL_CAP];
   logic [7:0]               upper_left_bytes [PIXEL_CAP];
   int unsigned              row_pos;
   filter_type               cur_filter;
   logic                     err_seen;
   logic [BPP_W-1:0]         cfg_bpp = BPP_RESET;
   logic [LINE_LENGTH_W-1:0] cfg_len = LINE_LENGTH_RESET;

   stream_byte_type  byte_stream [$];
   pixel_result_type expected_pixels [$];

   int  failures = 0;
   int  cycle_count = 0;
   int  bytes_accepted = 0;
   int  idle_pct = IDLE_PCT;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  req_taken = 1'b0;

   function automatic void clear_image_state();
      foreach (above_bytes[i]) above_bytes[i] = 8'h00;
      foreach (left_bytes[i]) left_bytes[i] = 8'h00;
      foreach (upper_left_bytes[i]) upper_left_bytes[i] = 8'h00;
      row_pos = 0;
      cur_filter = FILT_NONE;
      err_seen = 1'b0;
   endfunction

   function automatic int unsigned row_span();
      if (cfg_len < 2) return 2;
      if (cfg_len > LINE_CAP) return LINE_CAP;
      return int'(cfg_len);
   endfunction

   function automatic pixel_result_type unfilter_byte(stream_byte_type beat);
      pixel_result_type res;
      int unsigned      bpp, len, slot;
      int               a, b, c, pred, pa, pb, pc;
      logic [7:0]       pix;
      if (beat.start) clear_image_state();
      bpp = (cfg_bpp == 0) ? 1 : (cfg_bpp > PIXEL_CAP) ? PIXEL_CAP : int'(cfg_bpp);
      len = row_span();
      res = '0;
      res.row_end = (row_pos >= len - 1);
      if (row_pos == 0) begin
         res.filter_slot = 1'b1;
         foreach (left_bytes[i]) left_bytes[i] = 8'h00;
         if (beat.data > FILT_PAETH) begin
            err_seen = 1'b1;
         end else begin
            cur_filter = filter_type'(beat.data[2:0]);
         end
      end else if (!err_seen) begin
         slot = (row_pos - 1) % bpp;
         a = int'(left_bytes[slot]);
         b = int'(above_bytes[row_pos]);
         // The upper-left neighbor only exists from the second pixel on.
         c = (row_pos > bpp) ? int'(upper_left_bytes[slot]) : 0;
         case (cur_filter)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = (a + b) >> 1;
            FILT_PAETH: begin
               pa = b - c;
               pb = a - c;
               pc = a + b - 2 * c;
               if (pa < 0) pa = -pa;
               if (pb < 0) pb = -pb;
               if (pc < 0) pc = -pc;
               if (pa <= pb && pa <= pc) pred = a;
               else if (pb <= pc) pred = b;
               else pred = c;
            end
            default:    pred = 0;
         endcase
         pix = beat.data + pred[7:0];
         upper_left_bytes[slot] = b[7:0];
         above_bytes[row_pos] = pix;
         left_bytes[slot] = pix;
         res.pixel = pix;
      end
      row_pos = res.row_end ? 0 : row_pos + 1;
      res.bad = err_seen;
      return res;
   endfunction

   task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         failures++;
      end
   endtask

   // Results are checked before the new request beat is predicted; with the input and
   // result registers in between, a beat can never answer the request taken at the same edge.
   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected result beat, actual pixel %h", $time, rsp_pixel_byte);
               failures++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("pixel_byte", want.pixel, rsp_pixel_byte);
               check_field("is_filter_slot", 8'(want.filter_slot), 8'(rsp_is_filter_slot));
               check_field("row_end", 8'(want.row_end), 8'(rsp_row_end));
               check_field("bad_filter", 8'(want.bad), 8'(rsp_bad_filter));
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            expected_pixels.push_back(unfilter_byte({req_data_byte, req_image_start}));
            bytes_accepted++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("Test completed with failures");
         $finish;
      end
   end

   // A stalled beat is held; a new one is offered only when the slot is free.
   always @(negedge clock) begin
      logic            next_valid;
      stream_byte_type nb;
      next_valid = req_valid && !req_taken;
      if (!next_valid && byte_stream.size() != 0 && $urandom_range(99) >= idle_pct) begin
         nb = byte_stream.pop_front();
         req_data_byte <= nb.data;
         req_image_start <= nb.start;
         next_valid = 1'b1;
      end
      req_valid <= next_valid;
   end

   always @(negedge clock) begin
      if (!hold_done && bytes_accepted >= HOLD_TRIGGER) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (idx == REG_BYTES_PER_PIXEL) cfg_bpp = value[BPP_W-1:0];
      else cfg_len = value[LINE_LENGTH_W-1:0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic drain();
      while (byte_stream.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(posedge clock);
   endtask

   // Well-formed rows with random content: filter bytes land where a row starts.
   // A few filter codes are invalid and a few image starts fall mid-row.
   task automatic queue_stream(int count, bit fresh_image, int start_pct);
      stream_byte_type sb;
      int unsigned     pos, len;
      pos = row_pos;
      len = row_span();
      for (int n = 0; n < count; n++) begin
         sb.start = (n == 0 && fresh_image) || ($urandom_range(99) < start_pct);
         if (sb.start) pos = 0;
         if (pos == 0) begin
            sb.data = ($urandom_range(99) < 3) ? 8'($urandom_range(255, 5))
                                                : 8'($urandom_range(4, 0));
         end else begin
            case ($urandom_range(9))
               0:       sb.data = 8'h00;
               1:       sb.data = 8'hFF;
               default: sb.data = 8'($urandom_range(255));
            endcase
         end
         byte_stream.push_back(sb);
         pos = (pos >= len - 1) ? 0 : pos + 1;
      end
   endtask

   initial begin
      logic [7:0] directed_bytes [30];
      directed_bytes = '{
         FILT_NONE,       8'hFF, 8'h00, 8'h80,
         FILT_SUB,        8'h01, 8'hFF, 8'h7F,
         FILT_UP,         8'hFF, 8'h01, 8'h00,
         FILT_AVG,        8'hFF, 8'hFF, 8'h02,
         FILT_PAETH,      8'h80, 8'h7F, 8'hFF,
         FILTER_CODE_BAD, 8'h12, 8'h34, 8'h56,
         FILT_UP,         8'h11,
         FILT_PAETH,      8'h10, 8'h20, 8'h30
      };
      clear_image_state();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Four-byte rows of single-byte pixels: every filter, an invalid code that
      // poisons the image, and an image start in the middle of a row that clears it.
      csr_write(REG_BYTES_PER_PIXEL, 32'd1);
      csr_write(REG_LINE_LENGTH, 32'd4);
      foreach (directed_bytes[i])
         byte_stream.push_back('{data: directed_bytes[i], start: (i == 0 || i == 26)});
      drain();

      csr_write(REG_BYTES_PER_PIXEL, 32'd3);
      csr_write(REG_LINE_LENGTH, 32'd13);
      queue_stream(150, 1'b1, 2);
      drain();

      csr_write(REG_BYTES_PER_PIXEL, 32'd8);
      csr_write(REG_LINE_LENGTH, 32'd2);
      queue_stream(100, 1'b0, 2);
      drain();

      // Only the low bits land in the registers; zero is then clamped up.
      csr_write(REG_BYTES_PER_PIXEL, 32'hFFFF_FFF0);
      csr_write(REG_LINE_LENGTH, 32'd0);
      queue_stream(60, 1'b1, 2);
      drain();

      // The long receiver hold-off falls in this phase.
      csr_write(REG_BYTES_PER_PIXEL, 32'd15);
      csr_write(REG_LINE_LENGTH, 32'd37);
      queue_stream(230, 1'b1, 2);
      drain();

      // The row is shortened under the current column; no idling on either side.
      idle_pct = 0;
      csr_write(REG_BYTES_PER_PIXEL, 32'd2);
      csr_write(REG_LINE_LENGTH, 32'd5);
      queue_stream(150, 1'b0, 2);
      drain();
      idle_pct = IDLE_PCT;

      csr_write(REG_BYTES_PER_PIXEL, 32'd6);
      csr_write(REG_LINE_LENGTH, 32'd8191);
      queue_stream(150, 1'b1, 0);
      drain();

      csr_write(REG_BYTES_PER_PIXEL, 32'd9);
      csr_write(REG_LINE_LENGTH, 32'd20);
      queue_stream(200, 1'b0, 2);
      drain();

      csr_write(REG_BYTES_PER_PIXEL, 32'd5);
      csr_write(REG_LINE_LENGTH, 32'd600);
      queue_stream(150, 1'b1, 1);
      drain();

      csr_write(REG_BYTES_PER_PIXEL, 32'd4);
      csr_write(REG_LINE_LENGTH, 32'd4096);
      queue_stream(60, 1'b1, 2);
      drain();

      repeat (8) @(posedge clock);
      if (failures == 0 && expected_pixels.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/pngu_pkg.sv
rtl/pngu_predict.sv
rtl/png_scanline_unfilter.sv
verif/png_scanline_unfilter_tb.sv
